// ===== rtl/core/smfr_pkg.sv =====
// Shared constants, request and mode codes, and controller/datapath interface types.
package smfr_pkg;

    // Default widths of the timer and of the alpha fraction
    localparam int TIME_BITS_DEF       = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int REQ_W  = 2;
    localparam int DUR_W  = 16;
    localparam int MODE_W = 2;

    // Fade length after reset, in ticks
    localparam int RESET_LENGTH = 23;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_IN    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OUT   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POLL  = 2'd3;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul1;
        logic mul2;
        logic finish;
        logic post;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_curve;
    } t_status;

endpackage

// ===== rtl/core/smfr_ctrl.sv =====
// Sequencer that steps one request word through accept, then for a curve tick divide, multiply and finish, and post.
module smfr_ctrl #(
    parameter int ALPHA_FRAC_BITS = smfr_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  smfr_pkg::t_status i_status,
    output logic             o_in_ready,
    output smfr_pkg::t_cmd   o_cmd
);

    localparam int F  = ALPHA_FRAC_BITS;
    localparam int CW = $clog2(F);

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_FIN,
        ST_POST
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    // Decode commands from the present state
    always_comb begin
        o_in_ready      = (r_state == ST_WAIT);
        o_cmd.accept    = (r_state == ST_WAIT) && i_in_valid;
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.mul1      = (r_state == ST_MUL1);
        o_cmd.mul2      = (r_state == ST_MUL2);
        o_cmd.finish    = (r_state == ST_FIN);
        o_cmd.post      = (r_state == ST_POST) && i_out_free;
    end

    // Next state and divide step count
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_WAIT: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = i_status.need_curve ? ST_DIV : ST_POST;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(F - 1)) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_FIN;
            ST_FIN:  n_state = ST_POST;
            ST_POST: begin
                if (i_out_free) begin
                    n_state = ST_WAIT;
                end
            end
            default: n_state = ST_WAIT;
        endcase
    end

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/smfr_datapath.sv =====
// Fade state registers, restoring divider and smoothstep multiplier chain.
module smfr_datapath #(
    parameter int TIME_BITS       = smfr_pkg::TIME_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = smfr_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smfr_pkg::t_cmd                 i_cmd,
    input  logic [smfr_pkg::REQ_W-1:0]     i_req,
    input  logic [smfr_pkg::DUR_W-1:0]     i_dur,
    output smfr_pkg::t_status              o_status,
    output logic [ALPHA_FRAC_BITS:0]       o_alpha,
    output logic [smfr_pkg::MODE_W-1:0]    o_mode,
    output logic                           o_active,
    output logic                           o_seen
);

    localparam int TW = TIME_BITS;
    localparam int F  = ALPHA_FRAC_BITS;
    localparam int PW = 2 * F + 3;

    localparam logic [F:0]      ALPHA_ONE = (F + 1)'(1) << F;
    localparam logic [F+1:0]    K_THREE   = (F + 2)'(3) << F;
    localparam logic [2*F:0]    HALF_SQ   = (2 * F + 1)'(1) << (F - 1);
    localparam logic [PW-1:0]   HALF_PR   = PW'(1) << (F - 1);
    localparam logic [32:0]     TMAX33    = (33'd1 << TW) - 33'd1;

    // Fade state
    logic [smfr_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [TW-1:0]               r_elapsed, n_elapsed;
    logic [TW-1:0]               r_len, n_len;
    logic [F:0]                  r_opacity, n_opacity;
    logic                        r_done, n_done;
    logic                        r_seen, n_seen;

    // Arithmetic registers
    logic [TW:0]     r_rem;
    logic [F-1:0]    r_quo;
    logic [2*F-1:0]  r_sq;
    logic [F+1:0]    r_k;
    logic [PW-1:0]   r_prod;

    logic [TW-1:0]   e_inc;
    logic [TW-1:0]   len_clip;
    logic            fading;
    logic [TW:0]     rem_sh;
    logic            rem_ge;
    logic [2*F:0]    sq_rnd;
    logic [F:0]      u_val;
    logic [PW-1:0]   pr_rnd;
    logic [F+2:0]    s_val;
    logic [F:0]      s_sat;

    // Advance the count with saturation, clip a new length into range
    always_comb begin
        e_inc  = (r_elapsed == '1) ? r_elapsed : r_elapsed + TW'(1);
        fading = (r_mode == smfr_pkg::MODE_IN) || (r_mode == smfr_pkg::MODE_OUT);
        if (i_dur == '0) begin
            len_clip = TW'(1);
        end else if (32'(i_dur) > TMAX33[31:0]) begin
            len_clip = '1;
        end else begin
            len_clip = TW'(i_dur);
        end
        o_status.need_curve = (i_req == smfr_pkg::REQ_TICK) && fading && (e_inc < r_len);
    end

    // Divider step and curve arithmetic
    always_comb begin
        rem_sh = {r_rem[TW-1:0], 1'b0};
        rem_ge = (rem_sh >= {1'b0, r_len});
        sq_rnd = (2 * F + 1)'(r_sq) + HALF_SQ;
        u_val  = sq_rnd[2*F:F];
        pr_rnd = r_prod + HALF_PR;
        s_val  = pr_rnd[PW-1:F];
        s_sat  = (s_val > (F + 3)'(ALPHA_ONE)) ? ALPHA_ONE : s_val[F:0];
    end

    // Apply the request to the fade state
    always_comb begin
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        n_len     = r_len;
        n_opacity = r_opacity;
        n_done    = r_done;
        n_seen    = r_seen;
        if (i_cmd.accept) begin
            case (i_req)
                smfr_pkg::REQ_TICK: begin
                    if (fading) begin
                        if (e_inc >= r_len) begin
                            n_elapsed = r_len;
                            if (r_mode == smfr_pkg::MODE_IN) begin
                                n_mode    = smfr_pkg::MODE_IDLE;
                                n_opacity = '0;
                            end else begin
                                n_mode    = smfr_pkg::MODE_FULL;
                                n_opacity = ALPHA_ONE;
                                n_done    = 1'b1;
                            end
                        end else begin
                            n_elapsed = e_inc;
                        end
                    end else if (r_mode == smfr_pkg::MODE_FULL) begin
                        n_opacity = ALPHA_ONE;
                    end else begin
                        n_opacity = '0;
                    end
                end
                smfr_pkg::REQ_IN: begin
                    n_len     = len_clip;
                    n_elapsed = '0;
                    n_mode    = smfr_pkg::MODE_IN;
                    n_opacity = ALPHA_ONE;
                    n_done    = 1'b0;
                end
                smfr_pkg::REQ_OUT: begin
                    n_len     = len_clip;
                    n_elapsed = '0;
                    if (i_dur == '0) begin
                        // zero-length fade-out completes at once
                        n_mode    = smfr_pkg::MODE_FULL;
                        n_opacity = ALPHA_ONE;
                        n_done    = 1'b1;
                    end else begin
                        n_mode = smfr_pkg::MODE_OUT;
                        n_done = 1'b0;
                    end
                end
                default: ;
            endcase
            n_seen = n_done;
            if (i_req == smfr_pkg::REQ_POLL) begin
                n_done = 1'b0;
            end
        end
        if (i_cmd.finish) begin
            n_opacity = (r_mode == smfr_pkg::MODE_IN) ? (ALPHA_ONE - s_sat) : s_sat;
        end
    end

    // Hold fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= smfr_pkg::MODE_FULL;
            r_elapsed <= '0;
            r_len     <= TW'(smfr_pkg::RESET_LENGTH);
            r_opacity <= ALPHA_ONE;
            r_done    <= 1'b0;
            r_seen    <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_len     <= n_len;
            r_opacity <= n_opacity;
            r_done    <= n_done;
            r_seen    <= n_seen;
        end
    end

    // Divide one quotient bit per cycle, then square and scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem <= {1'b0, e_inc};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_len}) : rem_sh;
            r_quo <= {r_quo[F-2:0], rem_ge};
        end
        if (i_cmd.mul1) begin
            r_sq <= (2 * F)'(r_quo) * (2 * F)'(r_quo);
            r_k  <= K_THREE - (F + 2)'({r_quo, 1'b0});
        end
        if (i_cmd.mul2) begin
            r_prod <= PW'(u_val) * PW'(r_k);
        end
    end

    // Result fields from the state after the request
    assign o_alpha  = r_opacity;
    assign o_mode   = r_mode;
    assign o_active = (r_mode != smfr_pkg::MODE_IDLE) || (r_opacity != '0);
    assign o_seen   = r_seen;

endmodule

// ===== rtl/core/smoothstep_fade_ramp_controller.sv =====
// Top level of the smoothstep fade ramp controller with its output word register.
//
// Input channel (s side): one word per request. tuser carries the request kind
// (tick, start fade-in, start fade-out, poll), tdata the fade length in ticks.
// Output channel (m side): exactly one word per request, giving alpha, mode,
// active and the completion flag as they stand after that request.
// A tick that advances a running fade computes t = elapsed/length with a
// restoring divider, ALPHA_FRAC_BITS quotient bits at one quotient bit per cycle,
// then passes the multiply states MUL1 and MUL2 and the rounding state FIN
// before the post state. Every other request goes from acceptance straight to
// the post state. A new request word is taken only after the result of the
// previous one has been posted to the output register.
// The result sits in an output register, so the next request is accepted while
// a result still waits; when the receiver stalls, a finished second result
// holds in the sequencer and tready stays low until the register frees.
// Reset (synchronous, active low) sets mode full, alpha 1.0, length 23 ticks,
// count zero, flag clear, and empties the output register.
module smoothstep_fade_ramp_controller #(
    parameter int TIME_BITS       = smfr_pkg::TIME_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = smfr_pkg::ALPHA_FRAC_BITS_DEF,
    localparam int OUT_W = ((ALPHA_FRAC_BITS + 5 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [smfr_pkg::DUR_W-1:0]   i_s_tdata,   // duration_ticks
    input  logic [smfr_pkg::REQ_W-1:0]   i_s_tuser,   // req_type
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_W-1:0]             o_m_tdata    // alpha, mode, active, fade_out_done
);

    localparam int F = ALPHA_FRAC_BITS;

    smfr_pkg::t_cmd    cmd;
    smfr_pkg::t_status status;
    logic [F:0]                    alpha;
    logic [smfr_pkg::MODE_W-1:0]   mode;
    logic                          active;
    logic                          seen;
    logic                          out_free;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    smfr_ctrl #(
        .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    smfr_datapath #(
        .TIME_BITS      (TIME_BITS),
        .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_s_tuser),
        .i_dur    (i_s_tdata),
        .o_status (status),
        .o_alpha  (alpha),
        .o_mode   (mode),
        .o_active (active),
        .o_seen   (seen)
    );

    assign out_free = !r_out_valid || i_m_tready;

    // Load a result word when posted, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.post) begin
            r_out_data <= OUT_W'({seen, active, mode, alpha});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== tb/smoothstep_fade_ramp_controller_tb.sv =====
// Self-checking testbench for the smoothstep fade ramp controller stream block.
module smoothstep_fade_ramp_controller_tb;

    localparam int FRAC      = smfr_pkg::ALPHA_FRAC_BITS_DEF;
    localparam int TBITS     = smfr_pkg::TIME_BITS_DEF;
    localparam int REQ_BITS  = smfr_pkg::REQ_W;
    localparam int DUR_BITS  = smfr_pkg::DUR_W;
    localparam int MODE_BITS = smfr_pkg::MODE_W;
    localparam int OUT_BITS  = ((FRAC + 5 + 7) / 8) * 8;
    localparam logic [63:0] ALPHA_ONE  = 64'd1 << FRAC;
    localparam logic [63:0] ALPHA_HALF = 64'd1 << (FRAC - 1);
    localparam logic [63:0] TIME_TOP   = (64'd1 << TBITS) - 64'd1;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 150;

    // One output word split into its fields
    typedef struct packed {
        logic [FRAC:0]        alpha;
        logic [MODE_BITS-1:0] mode;
        logic                 active;
        logic                 done;
    } t_fade_word;

    // One request word, with an optional hand-written expectation
    typedef struct {
        logic [REQ_BITS-1:0] req;
        logic [DUR_BITS-1:0] dur;
        bit                  typed;
        t_fade_word          want;
    } t_fade_req;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DUR_BITS-1:0] s_tdata = '0;   // duration_ticks
    logic [REQ_BITS-1:0] s_tuser = '0;   // req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;        // alpha, mode, active, fade_out_done

    t_fade_req  requests[$];
    t_fade_word words_due[$];
    int unsigned sent = 0;
    int unsigned words_seen = 0;
    int unsigned errors = 0;

    // Predictor state
    logic [MODE_BITS-1:0] fade_mode;
    logic [63:0]          elapsed;
    logic [63:0]          fade_len;
    logic [63:0]          opacity;
    logic                 done_flag;

    smoothstep_fade_ramp_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned n,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch word %0d %s: got %0d expected %0d", n, what, got, want);
        errors++;
    endtask

    function automatic logic [63:0] fit_length(input logic [63:0] d);
        logic [63:0] r;
        r = (d == 64'd0) ? 64'd1 : d;
        if (r > TIME_TOP) begin
            r = TIME_TOP;
        end
        return r;
    endfunction

    // Smoothstep of num/den, rounded half up at each product
    function automatic logic [63:0] smooth_curve(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] s;
        if (den == 64'd0) begin
            return ALPHA_ONE;
        end
        t = (num << FRAC) / den;
        if (t > ALPHA_ONE) begin
            t = ALPHA_ONE;
        end
        u = (t * t + ALPHA_HALF) >> FRAC;
        s = (u * (3 * ALPHA_ONE - 2 * t) + ALPHA_HALF) >> FRAC;
        if (s > ALPHA_ONE) begin
            s = ALPHA_ONE;
        end
        return s;
    endfunction

    task automatic reset_fade();
        fade_mode = smfr_pkg::MODE_FULL;
        elapsed   = 64'd0;
        fade_len  = fit_length(smfr_pkg::RESET_LENGTH);
        opacity   = ALPHA_ONE;
        done_flag = 1'b0;
    endtask

    // Apply one request to the predicted state and form the word it causes
    task automatic advance_fade(input logic [REQ_BITS-1:0] req, input logic [DUR_BITS-1:0] dur,
                                output t_fade_word w);
        logic [63:0] s;
        logic        seen;
        case (req)
            smfr_pkg::REQ_TICK: begin
                if (fade_mode == smfr_pkg::MODE_IN || fade_mode == smfr_pkg::MODE_OUT) begin
                    if (elapsed < TIME_TOP) begin
                        elapsed = elapsed + 64'd1;
                    end
                    if (elapsed >= fade_len) begin
                        elapsed = fade_len;
                        if (fade_mode == smfr_pkg::MODE_IN) begin
                            fade_mode = smfr_pkg::MODE_IDLE;
                            opacity   = 64'd0;
                        end else begin
                            fade_mode = smfr_pkg::MODE_FULL;
                            opacity   = ALPHA_ONE;
                            done_flag = 1'b1;
                        end
                    end else begin
                        s = smooth_curve(elapsed, fade_len);
                        opacity = (fade_mode == smfr_pkg::MODE_IN) ? ALPHA_ONE - s : s;
                    end
                end else if (fade_mode == smfr_pkg::MODE_FULL) begin
                    opacity = ALPHA_ONE;
                end else begin
                    opacity = 64'd0;
                end
            end
            smfr_pkg::REQ_IN: begin
                fade_len  = fit_length(dur);
                elapsed   = 64'd0;
                fade_mode = smfr_pkg::MODE_IN;
                opacity   = ALPHA_ONE;
                done_flag = 1'b0;
            end
            smfr_pkg::REQ_OUT: begin
                fade_len  = fit_length(dur);
                elapsed   = 64'd0;
                fade_mode = smfr_pkg::MODE_OUT;
                done_flag = 1'b0;
                // zero-length fade-out completes at once
                if (dur == '0) begin
                    fade_mode = smfr_pkg::MODE_FULL;
                    opacity   = ALPHA_ONE;
                    done_flag = 1'b1;
                end
            end
            default: begin
            end
        endcase
        seen = done_flag;
        if (req == smfr_pkg::REQ_POLL) begin
            done_flag = 1'b0;
        end
        w.alpha  = opacity[FRAC:0];
        w.mode   = fade_mode;
        w.active = (fade_mode != smfr_pkg::MODE_IDLE || opacity != 64'd0);
        w.done   = seen;
    endtask

    task automatic add_request(input logic [REQ_BITS-1:0] req, input logic [DUR_BITS-1:0] dur,
                               input bit typed, input t_fade_word want);
        t_fade_req r;
        r.req   = req;
        r.dur   = dur;
        r.typed = typed;
        r.want  = want;
        requests.push_back(r);
    endtask

    // Build the directed table and the random sequences
    task automatic build_requests();
        t_fade_word full_clr;
        t_fade_word full_set;
        t_fade_word idle_w;
        t_fade_word in_start;
        t_fade_word out_dark;
        t_fade_word none;
        int unsigned pick;
        int unsigned sel;
        int unsigned ticks;
        logic [REQ_BITS-1:0] req;
        logic [DUR_BITS-1:0] dur;
        full_clr = '{alpha: ALPHA_ONE[FRAC:0], mode: smfr_pkg::MODE_FULL, active: 1'b1,
                     done: 1'b0};
        full_set = '{alpha: ALPHA_ONE[FRAC:0], mode: smfr_pkg::MODE_FULL, active: 1'b1,
                     done: 1'b1};
        idle_w   = '{alpha: '0, mode: smfr_pkg::MODE_IDLE, active: 1'b0, done: 1'b0};
        in_start = '{alpha: ALPHA_ONE[FRAC:0], mode: smfr_pkg::MODE_IN, active: 1'b1,
                     done: 1'b0};
        out_dark = '{alpha: '0, mode: smfr_pkg::MODE_OUT, active: 1'b1, done: 1'b0};
        none     = '0;

        // state after reset, tick in full
        add_request(smfr_pkg::REQ_POLL, 16'h0000, 1, full_clr);
        add_request(smfr_pkg::REQ_TICK, 16'hFFFF, 1, full_clr);
        // zero-length fade-out, then read and clear the flag
        add_request(smfr_pkg::REQ_OUT,  16'h0000, 1, full_set);
        add_request(smfr_pkg::REQ_POLL, 16'h0000, 1, full_set);
        add_request(smfr_pkg::REQ_POLL, 16'h0000, 1, full_clr);
        // zero-length fade-in ends on the first tick; tick in idle
        add_request(smfr_pkg::REQ_IN,   16'h0000, 1, in_start);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 1, idle_w);
        add_request(smfr_pkg::REQ_TICK, 16'h1234, 1, idle_w);
        add_request(smfr_pkg::REQ_POLL, 16'hFFFF, 1, idle_w);
        // longest fade-out keeps alpha until the next tick
        add_request(smfr_pkg::REQ_OUT,  16'hFFFF, 1, out_dark);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        // short fade-in run to its end
        add_request(smfr_pkg::REQ_IN,   16'h0004, 1, in_start);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 1, idle_w);
        // short fade-out run to completion
        add_request(smfr_pkg::REQ_OUT,  16'h0003, 1, out_dark);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 1, full_set);
        add_request(smfr_pkg::REQ_POLL, 16'h0000, 1, full_set);
        // restart in the middle of a fade
        add_request(smfr_pkg::REQ_IN,   16'hAAAA, 1, in_start);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);
        add_request(smfr_pkg::REQ_OUT,  16'h5555, 0, none);
        add_request(smfr_pkg::REQ_TICK, 16'h0000, 0, none);

        // mostly whole fades with random lengths, some noise between them
        while (requests.size() < RANDOM_ITEMS + 26) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                req = (pick < 4) ? smfr_pkg::REQ_IN : smfr_pkg::REQ_OUT;
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    dur = DUR_BITS'($urandom_range(0, 24));
                end else if (sel < 9) begin
                    dur = DUR_BITS'($urandom_range(25, 600));
                end else begin
                    dur = DUR_BITS'($urandom);
                end
                add_request(req, dur, 0, none);
                ticks = (dur < 40) ? int'(dur) + $urandom_range(0, 3) : $urandom_range(1, 40);
                repeat (ticks) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_request(smfr_pkg::REQ_POLL, DUR_BITS'($urandom), 0, none);
                    end
                    add_request(smfr_pkg::REQ_TICK, DUR_BITS'($urandom), 0, none);
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_request(smfr_pkg::REQ_POLL, DUR_BITS'($urandom), 0, none);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    add_request(REQ_BITS'($urandom_range(0, 3)), DUR_BITS'($urandom), 0, none);
                end
            end
        end
    endtask

    // Drive request words in bursts and predict each accepted one
    always @(posedge i_clk) begin : drive_requests
        int unsigned burst_left;
        int unsigned gap_left;
        logic        next_valid;
        t_fade_word  w;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                advance_fade(requests[sent].req, requests[sent].dur, w);
                if (requests[sent].typed) begin
                    w = requests[sent].want;
                end
                words_due.push_back(w);
                sent++;
            end
            if (s_tvalid && !s_tready) begin
                next_valid = 1'b1;
            end else if (gap_left == 0 && sent < requests.size()) begin
                next_valid = 1'b1;
                s_tdata <= requests[sent].dur;
                s_tuser <= requests[sent].req;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
            end
            s_tvalid <= next_valid;
        end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = 0;
        end
    end

    // Stall the result side in stretches of changing pattern, with one long hold
    always @(posedge i_clk) begin : drive_ready
        int unsigned stretch_left;
        int unsigned pattern;
        int unsigned hold_left;
        int unsigned phase;
        bit          held;
        logic        ready;
        if (i_rst_n) begin
            if (!held && words_seen >= HOLD_AT_WORD) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(32, 200);
                pattern      = $urandom_range(0, 3);
            end
            stretch_left--;
            phase++;
            case (pattern)
                0:       ready = 1'b1;
                1:       ready = ($urandom_range(0, 2) != 0);
                2:       ready = (phase % 8) < 5;
                default: ready = ($urandom_range(0, 7) == 0);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end
            m_tready <= ready;
        end else begin
            stretch_left = 0;
            hold_left    = 0;
            held         = 1'b0;
            phase        = 0;
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_fade_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (words_due.size() == 0) begin
                report_mismatch("unexpected word", words_seen, 32'(m_tdata), 32'd0);
            end else begin
                want = words_due.pop_front();
                if (m_tdata[FRAC:0] !== want.alpha) begin
                    report_mismatch("alpha", words_seen, 32'(m_tdata[FRAC:0]), 32'(want.alpha));
                end
                if (m_tdata[FRAC+2:FRAC+1] !== want.mode) begin
                    report_mismatch("mode", words_seen, 32'(m_tdata[FRAC+2:FRAC+1]),
                                    32'(want.mode));
                end
                if (m_tdata[FRAC+3] !== want.active) begin
                    report_mismatch("active", words_seen, 32'(m_tdata[FRAC+3]),
                                    32'(want.active));
                end
                if (m_tdata[FRAC+4] !== want.done) begin
                    report_mismatch("fade_out_done", words_seen, 32'(m_tdata[FRAC+4]),
                                    32'(want.done));
                end
                if (m_tdata[OUT_BITS-1:FRAC+5] !== '0) begin
                    report_mismatch("padding", words_seen, 32'(m_tdata[OUT_BITS-1:FRAC+5]),
                                    32'd0);
                end
            end
            words_seen++;
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet;
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("smoothstep_fade_ramp_controller verification failed");
                $finish;
            end
        end
    end

    initial begin
        reset_fade();
        build_requests();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for all requests, then for every predicted word
        while (sent < requests.size()) @(posedge i_clk);
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("smoothstep_fade_ramp_controller verification clean");
        end else begin
            $display("smoothstep_fade_ramp_controller verification failed");
        end
        $finish;
    end

endmodule
